/* rtl/core/ppt_pkg.sv */
// Types, codes and constants shared by the position and PnL tracker.
// Depends on nothing. All other files use it by scoped names.
package ppt_pkg;

    // Actions carried in an input item
    localparam logic [1:0] ACT_TRADE = 2'd0;
    localparam logic [1:0] ACT_MARK  = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;
    // spare code, handled as a query
    localparam logic [1:0] ACT_RSVD  = 2'd3;

    // Quotient bits produced by the restoring divider
    localparam int DIV_STEPS = 48;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  symbol_index;
        logic [63:0] order_id;
        logic [63:0] buy_order_id;
        logic [63:0] sell_order_id;
        logic [23:0] quantity;
        logic [47:0] price;
    } t_item;

    typedef struct packed {
        logic               found;
        logic signed [31:0] net_position;
        logic [47:0]        average_price;
        logic signed [63:0] realized_pnl;
        logic [47:0]        mark_price;
        logic               saturated;
    } t_result;

    // One stored record
    typedef struct packed {
        logic [31:0] pos;
        logic [47:0] avg;
        logic [63:0] pnl;
        logic [47:0] mark;
    } t_rec;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_READ,
        OP_FETCH,
        OP_MARK,
        OP_SIDE_INIT,
        OP_CLOSE_SETUP,
        OP_MUL,
        OP_ACC,
        OP_PNL,
        OP_EXT_SETUP,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_EXT_DONE,
        OP_WRITE,
        OP_OUT
    } t_dp_op;

    // Multiplier operand pairs
    typedef enum logic [1:0] {
        MS_DIFF,
        MS_AVG,
        MS_PRICE
    } t_mul_sel;

    typedef struct packed {
        t_dp_op   op;
        logic     buy;
        t_mul_sel sel;
        logic     hi;
    } t_dp_cmd;

    typedef struct packed {
        logic in_range;
        logic is_trade;
        logic is_mark;
        logic sell_hit;
        logic buy_hit;
        logic pos_pos;
        logic pos_neg;
        logic qty_nz;
        logic out_free;
    } t_dp_sts;

    typedef enum logic [4:0] {
        S_IDLE,
        S_READ,
        S_FETCH,
        S_DISPATCH,
        S_MARK,
        S_SIDE,
        S_CLOSE,
        S_MUL,
        S_ACC,
        S_PNL,
        S_CHK_EXT,
        S_EXT,
        S_DIV_INIT,
        S_DIV,
        S_EXT_DONE,
        S_SIDE_END,
        S_WRITE,
        S_OUT
    } t_state;

endpackage

/* rtl/core/ppt_if.sv */
// Valid/ready channel interfaces for input items and result items.
// Depends on ppt_pkg for the payload types.
interface ppt_item_if;
    logic          valid;
    logic          ready;
    ppt_pkg::t_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ppt_result_if;
    logic             valid;
    logic             ready;
    ppt_pkg::t_result data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/ppt_ctrl.sv */
// Sequencer of the tracker: fetch, then trade sides or mark and write, then output.
// Depends on ppt_pkg for state, command and status types.
module ppt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ppt_pkg::t_dp_sts  i_sts,
    output ppt_pkg::t_dp_cmd  o_cmd
);

    ppt_pkg::t_state r_state, n_state;
    logic            r_buy, n_buy;
    logic            r_ext, n_ext;
    logic [1:0]      r_step, n_step;
    logic [5:0]      r_cnt, n_cnt;
    logic            mul_last;

    // last partial product: two for a close, four for an extension
    assign mul_last = r_ext ? (r_step == 2'd3) : (r_step == 2'd1);

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ppt_pkg::S_IDLE;
            r_buy   <= 1'b0;
            r_ext   <= 1'b0;
            r_step  <= 2'd0;
            r_cnt   <= 6'd0;
        end else begin
            r_state <= n_state;
            r_buy   <= n_buy;
            r_ext   <= n_ext;
            r_step  <= n_step;
            r_cnt   <= n_cnt;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_buy   = r_buy;
        n_ext   = r_ext;
        n_step  = r_step;
        n_cnt   = r_cnt;
        case (r_state)
            ppt_pkg::S_IDLE: begin
                if (i_in_valid) n_state = ppt_pkg::S_READ;
            end
            ppt_pkg::S_READ:  n_state = ppt_pkg::S_FETCH;
            ppt_pkg::S_FETCH: n_state = ppt_pkg::S_DISPATCH;
            ppt_pkg::S_DISPATCH: begin
                if (!i_sts.in_range) begin
                    n_state = ppt_pkg::S_OUT;
                end else if (i_sts.is_trade) begin
                    if (i_sts.sell_hit) begin
                        n_buy   = 1'b0;
                        n_state = ppt_pkg::S_SIDE;
                    end else if (i_sts.buy_hit) begin
                        n_buy   = 1'b1;
                        n_state = ppt_pkg::S_SIDE;
                    end else begin
                        n_state = ppt_pkg::S_OUT;
                    end
                end else if (i_sts.is_mark) begin
                    n_state = ppt_pkg::S_MARK;
                end else begin
                    n_state = ppt_pkg::S_OUT;
                end
            end
            ppt_pkg::S_MARK: n_state = ppt_pkg::S_WRITE;
            ppt_pkg::S_SIDE: begin
                if (r_buy ? i_sts.pos_neg : i_sts.pos_pos) n_state = ppt_pkg::S_CLOSE;
                else n_state = ppt_pkg::S_CHK_EXT;
            end
            ppt_pkg::S_CLOSE: begin
                n_ext   = 1'b0;
                n_step  = 2'd0;
                n_state = ppt_pkg::S_MUL;
            end
            ppt_pkg::S_MUL: n_state = ppt_pkg::S_ACC;
            ppt_pkg::S_ACC: begin
                if (mul_last) begin
                    n_state = r_ext ? ppt_pkg::S_DIV_INIT : ppt_pkg::S_PNL;
                end else begin
                    n_step  = r_step + 2'd1;
                    n_state = ppt_pkg::S_MUL;
                end
            end
            ppt_pkg::S_PNL: n_state = ppt_pkg::S_CHK_EXT;
            ppt_pkg::S_CHK_EXT: begin
                n_state = i_sts.qty_nz ? ppt_pkg::S_EXT : ppt_pkg::S_SIDE_END;
            end
            ppt_pkg::S_EXT: begin
                n_ext   = 1'b1;
                n_step  = 2'd0;
                n_state = ppt_pkg::S_MUL;
            end
            ppt_pkg::S_DIV_INIT: begin
                n_cnt   = 6'd0;
                n_state = ppt_pkg::S_DIV;
            end
            ppt_pkg::S_DIV: begin
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'(ppt_pkg::DIV_STEPS - 1)) n_state = ppt_pkg::S_EXT_DONE;
            end
            ppt_pkg::S_EXT_DONE: n_state = ppt_pkg::S_SIDE_END;
            ppt_pkg::S_SIDE_END: begin
                // sell side goes first; buy side follows when it is ours too
                if (!r_buy && i_sts.buy_hit) begin
                    n_buy   = 1'b1;
                    n_state = ppt_pkg::S_SIDE;
                end else begin
                    n_state = ppt_pkg::S_WRITE;
                end
            end
            ppt_pkg::S_WRITE: n_state = ppt_pkg::S_OUT;
            ppt_pkg::S_OUT: begin
                if (i_sts.out_free) n_state = ppt_pkg::S_IDLE;
            end
            default: n_state = ppt_pkg::S_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd.op   = ppt_pkg::OP_NONE;
        o_cmd.buy  = r_buy;
        o_cmd.hi   = r_step[0];
        if (!r_ext) o_cmd.sel = ppt_pkg::MS_DIFF;
        else if (r_step[1]) o_cmd.sel = ppt_pkg::MS_PRICE;
        else o_cmd.sel = ppt_pkg::MS_AVG;
        case (r_state)
            ppt_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_cmd.op = ppt_pkg::OP_LOAD;
            end
            ppt_pkg::S_READ:     o_cmd.op = ppt_pkg::OP_READ;
            ppt_pkg::S_FETCH:    o_cmd.op = ppt_pkg::OP_FETCH;
            ppt_pkg::S_MARK:     o_cmd.op = ppt_pkg::OP_MARK;
            ppt_pkg::S_SIDE:     o_cmd.op = ppt_pkg::OP_SIDE_INIT;
            ppt_pkg::S_CLOSE:    o_cmd.op = ppt_pkg::OP_CLOSE_SETUP;
            ppt_pkg::S_MUL:      o_cmd.op = ppt_pkg::OP_MUL;
            ppt_pkg::S_ACC:      o_cmd.op = ppt_pkg::OP_ACC;
            ppt_pkg::S_PNL:      o_cmd.op = ppt_pkg::OP_PNL;
            ppt_pkg::S_EXT:      o_cmd.op = ppt_pkg::OP_EXT_SETUP;
            ppt_pkg::S_DIV_INIT: o_cmd.op = ppt_pkg::OP_DIV_INIT;
            ppt_pkg::S_DIV:      o_cmd.op = ppt_pkg::OP_DIV_STEP;
            ppt_pkg::S_EXT_DONE: o_cmd.op = ppt_pkg::OP_EXT_DONE;
            ppt_pkg::S_WRITE:    o_cmd.op = ppt_pkg::OP_WRITE;
            ppt_pkg::S_OUT: begin
                if (i_sts.out_free) o_cmd.op = ppt_pkg::OP_OUT;
            end
            default: o_cmd.op = ppt_pkg::OP_NONE;
        endcase
    end

endmodule

/* rtl/core/ppt_dp.sv */
// Datapath of the tracker: record memory, valid bits, shared 24x32 multiplier,
// accumulator, PnL saturating adder, restoring divider and output register.
// Depends on ppt_pkg; driven by ppt_ctrl commands.
module ppt_dp #(
    parameter int SYMBOL_COUNT = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ppt_pkg::t_dp_cmd  i_cmd,
    input  ppt_pkg::t_item    i_item,
    input  logic              i_out_ready,
    output ppt_pkg::t_dp_sts  o_sts,
    output logic              o_out_valid,
    output ppt_pkg::t_result  o_result
);

    localparam int AW = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

    ppt_pkg::t_rec     mem [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0] r_vld;
    ppt_pkg::t_rec     r_rd;
    logic              r_rd_vld;

    ppt_pkg::t_item    r_in;
    logic              r_valid;
    logic [31:0]       r_pos;
    logic [47:0]       r_avg;
    logic [63:0]       r_pnl;
    logic [47:0]       r_mark;
    logic              r_sat;
    logic [23:0]       r_qty;
    logic [23:0]       r_close;
    logic [23:0]       r_applied;
    logic [31:0]       r_held;
    logic [31:0]       r_div;
    logic [47:0]       r_diff;
    logic              r_neg;
    logic [55:0]       r_prod;
    logic [79:0]       r_acc;
    logic [31:0]       r_rem;
    logic [47:0]       r_num;
    logic              r_ovld;
    ppt_pkg::t_result  r_res;

    logic [AW-1:0]     addr;
    logic [32:0]       abs33;
    logic [23:0]       close24;
    logic [47:0]       gain, cost;
    logic [32:0]       room33;
    logic              qty_gt;
    logic [23:0]       applied24;
    logic [32:0]       newm33;
    logic [23:0]       mul_a;
    logic [31:0]       mul_b;
    logic [55:0]       mul_p;
    logic signed [81:0] pnl_sum;
    logic              pnl_ovf;
    logic [32:0]       div_t;
    logic              div_ge;
    logic              in_range;

    assign addr     = AW'(r_in.symbol_index);
    assign in_range = (17'(r_in.symbol_index) < 17'(SYMBOL_COUNT));

    // close and extend arithmetic on the current record
    assign abs33     = r_pos[31] ? (33'd0 - {1'b1, r_pos}) : {1'b0, r_pos};
    assign close24   = ({9'd0, r_qty} < abs33) ? r_qty : abs33[23:0];
    assign gain      = i_cmd.buy ? r_avg : r_in.price;
    assign cost      = i_cmd.buy ? r_in.price : r_avg;
    assign room33    = i_cmd.buy ? (33'h0_7FFF_FFFF - abs33) : (33'h0_8000_0000 - abs33);
    assign qty_gt    = ({9'd0, r_qty} > room33);
    assign applied24 = qty_gt ? room33[23:0] : r_qty;
    assign newm33    = abs33 + {9'd0, applied24};

    // shared multiplier operands
    always_comb begin
        case (i_cmd.sel)
            ppt_pkg::MS_DIFF: begin
                mul_a = i_cmd.hi ? r_diff[47:24] : r_diff[23:0];
                mul_b = {8'd0, r_close};
            end
            ppt_pkg::MS_AVG: begin
                mul_a = i_cmd.hi ? r_avg[47:24] : r_avg[23:0];
                mul_b = r_held;
            end
            ppt_pkg::MS_PRICE: begin
                mul_a = i_cmd.hi ? r_in.price[47:24] : r_in.price[23:0];
                mul_b = {8'd0, r_applied};
            end
            default: begin
                mul_a = 24'd0;
                mul_b = 32'd0;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // PnL add with clamp to the signed 64-bit range
    assign pnl_sum = r_neg ? ($signed({{18{r_pnl[63]}}, r_pnl}) - $signed({2'b00, r_acc}))
                           : ($signed({{18{r_pnl[63]}}, r_pnl}) + $signed({2'b00, r_acc}));
    assign pnl_ovf = !((&pnl_sum[81:63]) || !(|pnl_sum[81:63]));

    // one restoring division step
    assign div_t  = {r_rem, r_num[47]};
    assign div_ge = (div_t >= {1'b0, r_div});

    // record memory and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == ppt_pkg::OP_READ) begin
            r_rd     <= mem[addr];
        end
        if (i_cmd.op == ppt_pkg::OP_WRITE) begin
            mem[addr] <= '{pos: r_pos, avg: r_avg, pnl: r_pnl, mark: r_mark};
        end
    end

    // valid bits and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
            r_ovld   <= 1'b0;
        end else begin
            if (i_cmd.op == ppt_pkg::OP_READ) r_rd_vld <= r_vld[addr];
            if (i_cmd.op == ppt_pkg::OP_WRITE) r_vld[addr] <= 1'b1;
            if (i_cmd.op == ppt_pkg::OP_OUT) r_ovld <= 1'b1;
            else if (i_out_ready) r_ovld <= 1'b0;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            ppt_pkg::OP_LOAD: begin
                r_in  <= i_item;
                r_sat <= 1'b0;
            end
            ppt_pkg::OP_FETCH: begin
                r_valid <= r_rd_vld;
                if (r_rd_vld) begin
                    r_pos  <= r_rd.pos;
                    r_avg  <= r_rd.avg;
                    r_pnl  <= r_rd.pnl;
                    r_mark <= r_rd.mark;
                end else begin
                    r_pos  <= 32'd0;
                    r_avg  <= 48'd0;
                    r_pnl  <= 64'd0;
                    r_mark <= 48'd0;
                end
            end
            ppt_pkg::OP_MARK: r_mark <= r_in.price;
            ppt_pkg::OP_SIDE_INIT: r_qty <= r_in.quantity;
            ppt_pkg::OP_CLOSE_SETUP: begin
                r_neg   <= (gain < cost);
                r_diff  <= (gain < cost) ? (cost - gain) : (gain - cost);
                r_close <= close24;
                r_qty   <= r_qty - close24;
                r_pos   <= i_cmd.buy ? (r_pos + {8'd0, close24}) : (r_pos - {8'd0, close24});
                if (abs33 == {9'd0, close24}) r_avg <= 48'd0;
                r_acc   <= 80'd0;
            end
            ppt_pkg::OP_MUL: r_prod <= mul_p;
            ppt_pkg::OP_ACC: begin
                r_acc <= r_acc + (i_cmd.hi ? {r_prod, 24'd0} : {24'd0, r_prod});
            end
            ppt_pkg::OP_PNL: begin
                if (pnl_ovf) begin
                    r_sat <= 1'b1;
                    r_pnl <= pnl_sum[81] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
                end else begin
                    r_pnl <= pnl_sum[63:0];
                end
            end
            ppt_pkg::OP_EXT_SETUP: begin
                r_held    <= abs33[31:0];
                r_applied <= applied24;
                r_div     <= newm33[31:0];
                if (qty_gt) r_sat <= 1'b1;
                r_acc     <= 80'd0;
            end
            ppt_pkg::OP_DIV_INIT: begin
                r_rem <= r_acc[79:48];
                r_num <= r_acc[47:0];
            end
            ppt_pkg::OP_DIV_STEP: begin
                r_rem <= div_ge ? (div_t[31:0] - r_div) : div_t[31:0];
                r_num <= {r_num[46:0], div_ge};
            end
            ppt_pkg::OP_EXT_DONE: begin
                r_avg <= r_num;
                r_pos <= i_cmd.buy ? r_div : (32'd0 - r_div);
            end
            ppt_pkg::OP_WRITE: r_valid <= 1'b1;
            ppt_pkg::OP_OUT: begin
                if (in_range && r_valid) begin
                    r_res.found         <= 1'b1;
                    r_res.net_position  <= $signed(r_pos);
                    r_res.average_price <= r_avg;
                    r_res.realized_pnl  <= $signed(r_pnl);
                    r_res.mark_price    <= r_mark;
                    r_res.saturated     <= r_sat;
                end else begin
                    r_res <= '0;
                end
            end
            default: ;
        endcase
    end

    // status to the controller
    assign o_sts.in_range = in_range;
    assign o_sts.is_trade = (r_in.action == ppt_pkg::ACT_TRADE);
    assign o_sts.is_mark  = (r_in.action == ppt_pkg::ACT_MARK);
    assign o_sts.sell_hit = (r_in.order_id == r_in.sell_order_id);
    assign o_sts.buy_hit  = (r_in.order_id == r_in.buy_order_id);
    assign o_sts.pos_pos  = !r_pos[31] && (r_pos != 32'd0);
    assign o_sts.pos_neg  = r_pos[31];
    assign o_sts.qty_nz   = (r_qty != 24'd0);
    assign o_sts.out_free = !r_ovld || i_out_ready;

    assign o_out_valid = r_ovld;
    assign o_result    = r_res;

endmodule

/* rtl/core/position_pnl_tracker_top.sv */
// Top level of the per-symbol position and PnL tracker.
// Depends on ppt_pkg, ppt_if, ppt_ctrl and ppt_dp.
//
//  channel   | dir | payload         | accepted when
//  ----------+-----+-----------------+-------------------------
//  i_item    | in  | ppt_pkg::t_item | valid && ready
//  o_result  | out | ppt_pkg::t_result | valid && ready
//
// One item at a time. A query or an out-of-range index goes from fetch to the
// output step; a mark also writes the record; a trade runs close and extend
// for each side that is ours, with a restoring divider for the new average.
// Reset is synchronous; all records read as empty afterwards, no clearing pass.
// A stalled result waits in the output register; the next item is taken
// meanwhile and held at its output step until the register frees.
module position_pnl_tracker_top #(
    parameter int SYMBOL_COUNT = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    ppt_item_if.sink            i_item,
    ppt_result_if.source        o_result
);

    ppt_pkg::t_dp_cmd cmd;
    ppt_pkg::t_dp_sts sts;

    ppt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (i_item.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ppt_dp #(
        .SYMBOL_COUNT (SYMBOL_COUNT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_item      (i_item.data),
        .i_out_ready (o_result.ready),
        .o_sts       (sts),
        .o_out_valid (o_result.valid),
        .o_result    (o_result.data)
    );

endmodule

/* rtl/core/ppt_chk.sv */
// Port-level checker for the tracker, attached to the top level by bind.
// Depends on ppt_pkg for the result type.
module ppt_chk (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input ppt_pkg::t_result i_out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result changed while stalled");

    // no result straight out of reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // one item at a time: ready drops after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second item taken while busy");

    // an empty record reports all zero
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.found |-> i_out_data == '0)
        else $error("fields set on a missing record");

endmodule

bind position_pnl_tracker_top ppt_chk u_ppt_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_data  (o_result.data)
);

/* verif/tb_position_pnl_tracker_top.sv */
// Testbench for position_pnl_tracker_top: directed and random items checked
// against a cycle-free prediction of the record table. Depends on ppt_pkg, ppt_if.
module tb_position_pnl_tracker_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SYMS = 256;
    localparam int WATCHDOG = 20000;

    // Record table prediction and expected result queue
    class pnl_scoreboard;
        bit          rec_valid [SYMS];
        longint      rec_pos   [SYMS];
        bit [47:0]   rec_avg   [SYMS];
        longint      rec_pnl   [SYMS];
        bit [47:0]   rec_mark  [SYMS];
        ppt_pkg::t_result pending[$];
        int          errors;
        int          checked;
        int          sat_seen;

        function void clear();
            foreach (rec_valid[i]) begin
                rec_valid[i] = 0; rec_pos[i] = 0; rec_avg[i] = 0;
                rec_pnl[i] = 0; rec_mark[i] = 0;
            end
        endfunction

        // Saturating add of (gain - cost) * units
        function longint pnl_close(longint p, bit [47:0] gain, bit [47:0] cost,
                                   longint units, ref bit sat);
            logic signed [130:0] sum;
            sum = $signed({83'd0, p[63:0]}) - (p < 0 ? (131'sd1 <<< 64) : 0)
                + ($signed({83'd0, gain}) - $signed({83'd0, cost}))
                  * $signed({67'd0, units[63:0]});
            if (sum > 131'sd9223372036854775807) begin
                sat = 1; return 64'h7fffffffffffffff;
            end
            if (sum < -131'sd9223372036854775808) begin
                sat = 1; return 64'h8000000000000000;
            end
            return sum[63:0];
        endfunction

        function void apply_side(int s, bit buy, longint qty, bit [47:0] price,
                                 ref bit sat);
            longint pos, held, room, applied, open, cls;
            bit [47:0] avg;
            bit [127:0] num, q;
            pos = rec_pos[s];
            avg = rec_avg[s];
            if ((buy && pos < 0) || (!buy && pos > 0)) begin
                open = buy ? -pos : pos;
                cls  = qty < open ? qty : open;
                rec_pnl[s] = buy ? pnl_close(rec_pnl[s], avg, price, cls, sat)
                                 : pnl_close(rec_pnl[s], price, avg, cls, sat);
                pos = buy ? pos + cls : pos - cls;
                qty -= cls;
                if (pos == 0) avg = 0;
            end
            if (qty > 0) begin
                held = buy ? pos : -pos;
                room = buy ? 64'd2147483647 - held : 64'd2147483648 - held;
                applied = qty;
                if (applied > room) begin
                    applied = room; sat = 1;
                end
                num = 128'(avg) * 128'(held) + 128'(price) * 128'(applied);
                q = (held + applied) == 0 ? 0 : num / 128'(held + applied);
                avg = q[47:0];
                pos = buy ? held + applied : -(held + applied);
            end
            rec_pos[s] = pos;
            rec_avg[s] = avg;
        endfunction

        // Note an accepted input item
        function void note_item(ppt_pkg::t_item it);
            ppt_pkg::t_result r;
            bit sat;
            int s;
            r = '0;
            sat = 0;
            s = it.symbol_index;
            if (it.action == ppt_pkg::ACT_TRADE) begin
                if (it.order_id == it.sell_order_id) begin
                    rec_valid[s] = 1;
                    apply_side(s, 0, longint'(it.quantity), it.price, sat);
                end
                if (it.order_id == it.buy_order_id) begin
                    rec_valid[s] = 1;
                    apply_side(s, 1, longint'(it.quantity), it.price, sat);
                end
            end else if (it.action == ppt_pkg::ACT_MARK) begin
                rec_valid[s] = 1;
                rec_mark[s] = it.price;
            end
            if (rec_valid[s]) begin
                r.found = 1;
                r.net_position = rec_pos[s][31:0];
                r.average_price = rec_avg[s];
                r.realized_pnl = rec_pnl[s];
                r.mark_price = rec_mark[s];
                r.saturated = sat;
            end
            pending.push_back(r);
        endfunction

        // Check one accepted result against the oldest expectation
        function void check_result(ppt_pkg::t_result got);
            ppt_pkg::t_result exp;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %p", $realtime, got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            checked++;
            if (got.saturated) sat_seen++;
            if (got !== exp) begin
                $display("%0t: mismatch expected %p actual %p", $realtime, exp, got);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    ppt_item_if   item_ch();
    ppt_result_if result_ch();

    position_pnl_tracker_top #(.SYMBOL_COUNT(SYMS)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(item_ch), .o_result(result_ch)
    );

    always #1 i_clk = ~i_clk;

    pnl_scoreboard book = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_off = 0;
    int idle_cycles = 0;
    bit [63:0] our_ids [4] = '{64'd0, 64'hffffffffffffffff, 64'h1234, 64'h55aa};

    initial begin
        item_ch.valid = 0;
        item_ch.data = '0;
        result_ch.ready = 0;
    end

    // Result side: random stalls, optional long hold-off
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (result_ch.valid && result_ch.ready)
                book.check_result(result_ch.data);
            result_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog on cycles with no accepted item on either channel
    always @(posedge i_clk) begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Offer one item and wait for its acceptance; valid stays up for the next
    task automatic send_item(ppt_pkg::t_item it);
        if ($urandom_range(99) < send_idle_pct) begin
            item_ch.valid <= 0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        item_ch.valid <= 1;
        item_ch.data  <= it;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        book.note_item(it);
    endtask

    // Drop valid after the last item of a burst
    task automatic stop_offer();
        item_ch.valid <= 0;
        @(posedge i_clk);
    endtask

    function automatic ppt_pkg::t_item make_trade(int s, bit buy, bit sell, int qty,
                                                  bit [47:0] px);
        ppt_pkg::t_item it;
        it = '0;
        it.action = ppt_pkg::ACT_TRADE;
        it.symbol_index = 8'(s);
        it.order_id = our_ids[$urandom_range(3)];
        it.buy_order_id  = buy  ? it.order_id : ~it.order_id;
        it.sell_order_id = sell ? it.order_id : it.order_id ^ {$urandom, $urandom | 1};
        it.quantity = 24'(qty);
        it.price = px;
        return it;
    endfunction

    // Random item: mostly matching trades on a few hot symbols
    function automatic ppt_pkg::t_item rand_item();
        ppt_pkg::t_item it;
        int k;
        int s;
        bit [47:0] px;
        k = $urandom_range(99);
        s = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(7);
        px = ($urandom_range(9) == 0) ? 48'({$urandom, $urandom})
             : 48'({$urandom_range(4000), 16'h0}) + 48'($urandom_range(65535));
        if (k < 70) begin
            it = make_trade(s, 1'($urandom_range(1)), 1'($urandom_range(1)),
                            ($urandom_range(19) == 0) ? {$urandom} : $urandom_range(3000), px);
            if (k < 8) it.quantity = 24'hffffff;
        end else begin
            it = '0;
            it.action = 2'($urandom_range(3));
            it.symbol_index = 8'(s);
            it.order_id = {$urandom, $urandom};
            it.buy_order_id = {$urandom, $urandom};
            it.sell_order_id = {$urandom, $urandom};
            it.quantity = 24'($urandom);
            it.price = px;
        end
        return it;
    endfunction

    initial begin
        ppt_pkg::t_item it;
        int phase;
        book.clear();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: empty query, mark, both-sided, zero qty, extremes
        it = '0; it.action = ppt_pkg::ACT_QUERY; send_item(it);
        it = '0; it.action = ppt_pkg::ACT_RSVD; it.symbol_index = 8'hff; send_item(it);
        it = '0; it.action = ppt_pkg::ACT_MARK; it.symbol_index = 8'd1; it.price = '1;
        send_item(it);
        send_item(make_trade(1, 1, 0, 100, 48'h10000));
        send_item(make_trade(1, 1, 0, 50, 48'h30000));
        send_item(make_trade(1, 0, 1, 150, 48'h20000));
        send_item(make_trade(1, 0, 1, 0, 48'h20000));
        send_item(make_trade(2, 1, 1, 77, 48'h50000));
        send_item(make_trade(3, 0, 0, 10, 48'h50000));
        it = '0; it.action = ppt_pkg::ACT_QUERY; it.symbol_index = 8'd3; send_item(it);
        send_item(make_trade(4, 0, 1, 24'hffffff, '1));
        send_item(make_trade(4, 1, 0, 24'hffffff, 48'h0));
        for (int i = 0; i < 130; i++) send_item(make_trade(5, 1, 0, 24'hffffff, '1));
        send_item(make_trade(5, 0, 1, 24'hffffff, 0));
        for (int i = 0; i < 130; i++) send_item(make_trade(6, 0, 1, 24'hffffff, '1));
        for (int i = 0; i < 300; i++) send_item(make_trade(6, 1, 0, 24'hffffff, 0));
        it = '0; it.action = ppt_pkg::ACT_QUERY; it.symbol_index = 8'd6; send_item(it);

        // Random phases with different idle and stall rates
        for (phase = 0; phase < 4; phase++) begin
            send_idle_pct  = (phase == 1 || phase == 3) ? (phase == 1 ? 85 : 33) : 0;
            recv_stall_pct = (phase == 2 || phase == 3) ? (phase == 2 ? 85 : 33) : 0;
            if (phase == 0) begin
                fork
                    begin
                        hold_off = 1;
                        repeat (800) @(posedge i_clk);
                        hold_off = 0;
                    end
                    begin
                        for (int i = 0; i < 8; i++) send_item(rand_item());
                        stop_offer();
                    end
                join
            end
            for (int i = 0; i < 180; i++) send_item(rand_item());
        end
        stop_offer();

        // Drain and settle
        while (book.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("checked %0d results, %0d with saturation, over four idle/stall phases",
                 book.checked, book.sat_seen);
        if (book.errors == 0 && book.pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
